[rtl/sorted_table_ceil_floor_search_top_macros.svh]
// Assertion macros shared by the sorted table search RTL.
`ifndef SORTED_TABLE_CEIL_FLOOR_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_CEIL_FLOOR_SEARCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define STCFS_ASSERT(label, clk_sig, rst_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
		else $error("assertion failed");
`define STCFS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define STCFS_ASSERT(label, clk_sig, rst_sig, prop)
`define STCFS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif
`endif

[rtl/stcfs_pkg.sv]
// Types, codes and microcode table of the sorted table search.
package stcfs_pkg;

	localparam int COUNT_W = 11;
	localparam int IDX_W = 10;
	localparam int FIELD_W = 32;
	localparam int CNT_W = COUNT_W + 2;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] pos_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic signed [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CEIL  = 2'd1,
		CMD_FLOOR = 2'd2
	} command_t;

	typedef enum logic [0:0] {
		CFG_ENTRY_COUNT = 1'b0,
		CFG_KEY_SIGNED  = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_BOUND,
		ST_LOOP,
		ST_DONE,
		ST_MISS
	} step_t;

	typedef enum logic [1:0] {
		ADDR_NONE,
		ADDR_BOUND,
		ADDR_MID,
		ADDR_NEXT
	} addr_sel_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_RESULT,
		OUT_ZERO
	} out_op_t;

	typedef enum logic [2:0] {
		COND_SEARCH,
		COND_EMPTY,
		COND_RANGE_MISS,
		COND_LOOP_GO,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic      take_in;
		addr_sel_t addr_sel;
		logic      init_bounds;
		logic      update_bounds;
		out_op_t   out_op;
		cond_t     cond;
		step_t     br_step;
		step_t     seq_step;
	} ctrl_word_t;

	typedef struct packed {
		logic search_in;
		logic empty;
		logic range_miss;
		logic loop_go;
		logic out_busy;
	} status_t;

	// When the condition holds the sequencer jumps to br_step, otherwise it goes to seq_step.
	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t w;
		unique case (step)
			ST_IDLE: w = '{take_in: 1'b1, addr_sel: ADDR_NONE, init_bounds: 1'b0,
				update_bounds: 1'b0, out_op: OUT_NONE, cond: COND_SEARCH,
				br_step: ST_START, seq_step: ST_IDLE};
			ST_START: w = '{take_in: 1'b0, addr_sel: ADDR_BOUND, init_bounds: 1'b1,
				update_bounds: 1'b0, out_op: OUT_NONE, cond: COND_EMPTY,
				br_step: ST_MISS, seq_step: ST_BOUND};
			ST_BOUND: w = '{take_in: 1'b0, addr_sel: ADDR_MID, init_bounds: 1'b0,
				update_bounds: 1'b0, out_op: OUT_NONE, cond: COND_RANGE_MISS,
				br_step: ST_MISS, seq_step: ST_LOOP};
			ST_LOOP: w = '{take_in: 1'b0, addr_sel: ADDR_NEXT, init_bounds: 1'b0,
				update_bounds: 1'b1, out_op: OUT_NONE, cond: COND_LOOP_GO,
				br_step: ST_LOOP, seq_step: ST_DONE};
			ST_DONE: w = '{take_in: 1'b0, addr_sel: ADDR_NONE, init_bounds: 1'b0,
				update_bounds: 1'b0, out_op: OUT_RESULT, cond: COND_OUT_BUSY,
				br_step: ST_DONE, seq_step: ST_IDLE};
			ST_MISS: w = '{take_in: 1'b0, addr_sel: ADDR_NONE, init_bounds: 1'b0,
				update_bounds: 1'b0, out_op: OUT_ZERO, cond: COND_OUT_BUSY,
				br_step: ST_MISS, seq_step: ST_IDLE};
			default: w = '{take_in: 1'b0, addr_sel: ADDR_NONE, init_bounds: 1'b0,
				update_bounds: 1'b0, out_op: OUT_NONE, cond: COND_SEARCH,
				br_step: ST_IDLE, seq_step: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/stcfs_table.sv]
// Key table memory with one write port and one registered read port.
module stcfs_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH = 32,
	parameter int ADDR_W = 10
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [KEY_WIDTH-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [KEY_WIDTH-1:0] rd_data
);

	logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/stcfs_seq.sv]
// Microcode sequencer: step counter, control word table and conditional jumps.
`include "sorted_table_ceil_floor_search_top_macros.svh"

module stcfs_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stcfs_pkg::status_t    status,
	output stcfs_pkg::ctrl_word_t ctrl
);

	stcfs_pkg::step_t step_q;
	stcfs_pkg::step_t step_nx;
	logic cond_true;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= stcfs_pkg::ST_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

	always_comb begin
		ctrl = stcfs_pkg::ucode_rom(step_q);
		unique case (ctrl.cond)
			stcfs_pkg::COND_SEARCH:     cond_true = status.search_in;
			stcfs_pkg::COND_EMPTY:      cond_true = status.empty;
			stcfs_pkg::COND_RANGE_MISS: cond_true = status.range_miss;
			stcfs_pkg::COND_LOOP_GO:    cond_true = status.loop_go;
			stcfs_pkg::COND_OUT_BUSY:   cond_true = status.out_busy;
			default:                    cond_true = 1'b0;
		endcase
		step_nx = cond_true ? ctrl.br_step : ctrl.seq_step;
	end

	`STCFS_ASSERT_NEXT(a_idle_holds, clk, arst_n, step_q == stcfs_pkg::ST_IDLE && !status.search_in, step_q == stcfs_pkg::ST_IDLE)

endmodule

[rtl/stcfs_dp.sv]
// Search datapath: bisection bounds, key compare and result register.
`include "sorted_table_ceil_floor_search_top_macros.svh"

module stcfs_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH = 32,
	parameter int ADDR_W = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stcfs_pkg::ctrl_word_t ctrl,
	input  logic                  in_valid,
	input  logic [1:0]            command,
	input  stcfs_pkg::field_t     search_key,
	input  stcfs_pkg::count_t     entry_count,
	input  logic                  key_signed,
	input  logic [KEY_WIDTH-1:0]  rd_data,
	input  logic                  out_ready,
	output stcfs_pkg::status_t    status,
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr,
	output logic                  out_valid,
	output logic                  found,
	output stcfs_pkg::pos_t       position,
	output stcfs_pkg::field_t     key_at_position
);

	logic [63:0] key_wide;
	logic [63:0] rd_wide;
	logic [31:0] addr_wide;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] flip;
	logic [KEY_WIDTH-1:0] key_c;
	logic [KEY_WIDTH-1:0] rd_c;
	logic ceil_q;
	stcfs_pkg::cnt_t lo_q;
	stcfs_pkg::cnt_t hi_q;
	stcfs_pkg::cnt_t mid_q;
	stcfs_pkg::cnt_t lo_nx;
	stcfs_pkg::cnt_t hi_nx;
	stcfs_pkg::cnt_t mid_nx;
	stcfs_pkg::cnt_t span;
	stcfs_pkg::cnt_t n_s;
	stcfs_pkg::cnt_t bound;
	stcfs_pkg::cnt_t addr_s;
	stcfs_pkg::count_t n_used;
	logic key_gt;
	logic key_lt;
	logic loop_go;
	logic in_fire;
	logic out_busy;
	logic out_load;
	logic hit;
	logic out_valid_q;
	logic found_q;
	stcfs_pkg::pos_t position_q;
	stcfs_pkg::field_t key_out_q;

	assign n_used = (32'(entry_count) > 32'(TABLE_DEPTH)) ?
		stcfs_pkg::count_t'(TABLE_DEPTH) : entry_count;
	assign n_s = stcfs_pkg::cnt_t'(n_used);
	assign key_wide = 64'(search_key);
	assign rd_wide = 64'(rd_data);

	assign flip = {key_signed, {(KEY_WIDTH-1){1'b0}}};
	assign key_c = key_q ^ flip;
	assign rd_c = rd_data ^ flip;
	assign key_gt = key_c > rd_c;
	assign key_lt = key_c < rd_c;

	always_comb begin
		lo_nx = lo_q;
		hi_nx = hi_q;
		if (ceil_q) begin
			if (key_gt) begin
				lo_nx = mid_q;
			end else begin
				hi_nx = mid_q;
			end
		end else begin
			if (key_lt) begin
				hi_nx = mid_q;
			end else begin
				lo_nx = mid_q;
			end
		end
		span = hi_nx - lo_nx;
		if (ceil_q) begin
			mid_nx = hi_nx - (span >>> 1);
			loop_go = mid_nx < hi_nx;
		end else begin
			mid_nx = lo_nx + (span >>> 1);
			loop_go = mid_nx > lo_nx;
		end
	end

	assign bound = ceil_q ? (n_s - stcfs_pkg::cnt_t'(1)) : '0;

	always_comb begin
		unique case (ctrl.addr_sel)
			stcfs_pkg::ADDR_NONE:  addr_s = mid_q;
			stcfs_pkg::ADDR_BOUND: addr_s = bound;
			stcfs_pkg::ADDR_MID:   addr_s = mid_q;
			stcfs_pkg::ADDR_NEXT:  addr_s = mid_nx;
			default:               addr_s = mid_q;
		endcase
	end

	assign addr_wide = 32'($unsigned(addr_s));
	assign rd_addr = addr_wide[ADDR_W-1:0];
	assign rd_en = ctrl.addr_sel != stcfs_pkg::ADDR_NONE;

	assign out_busy = out_valid_q && !out_ready;
	assign status.search_in = in_valid &&
		(command == stcfs_pkg::CMD_CEIL || command == stcfs_pkg::CMD_FLOOR);
	assign status.empty = n_used == '0;
	assign status.range_miss = ceil_q ? key_gt : key_lt;
	assign status.loop_go = loop_go;
	assign status.out_busy = out_busy;

	assign in_fire = ctrl.take_in && status.search_in;
	assign out_load = ctrl.out_op != stcfs_pkg::OUT_NONE && !out_busy;
	assign hit = mid_q >= stcfs_pkg::cnt_t'(0) && mid_q < n_s;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= key_wide[KEY_WIDTH-1:0];
			ceil_q <= command == stcfs_pkg::CMD_CEIL;
		end
		if (ctrl.init_bounds) begin
			lo_q <= stcfs_pkg::cnt_t'(-1);
			hi_q <= n_s;
			mid_q <= n_s >>> 1;
		end else if (ctrl.update_bounds) begin
			lo_q <= lo_nx;
			hi_q <= hi_nx;
			mid_q <= mid_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ctrl.out_op == stcfs_pkg::OUT_RESULT && hit) begin
				found_q <= 1'b1;
				position_q <= stcfs_pkg::pos_t'(mid_q);
				key_out_q <= rd_wide[31:0];
			end else begin
				found_q <= 1'b0;
				position_q <= '0;
				key_out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign position = position_q;
	assign key_at_position = key_out_q;

	`STCFS_ASSERT(a_mid_inside, clk, arst_n, ctrl.update_bounds |-> lo_q < mid_q && mid_q < hi_q)
	`STCFS_ASSERT_NEXT(a_out_loaded, clk, arst_n, out_load, out_valid_q)

endmodule

[rtl/sorted_table_ceil_floor_search_top.sv]
// Top level of the sorted table ceil and floor search block.
// A write item is taken while the block is idle and gives no result.
// A search passes the start and bound check steps, then bisects one step per cycle on
// the single table read port until the span closes, and then gives its result.
// A bound miss or an empty table gives a zero result; a search holds in_ready low until its result is loaded.
// Reset clears both registers to zero; table contents stay undefined until written.
`include "sorted_table_ceil_floor_search_top_macros.svh"

module sorted_table_ceil_floor_search_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [9:0]  entry_index,
	input  logic [31:0] write_value,
	input  logic [31:0] search_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [9:0]  position,
	output logic [31:0] key_at_position,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	stcfs_pkg::ctrl_word_t ctrl;
	stcfs_pkg::status_t status;
	stcfs_pkg::count_t entry_count_q;
	logic key_signed_q;
	logic [31:0] idx_wide;
	logic [63:0] wr_wide;
	logic wr_en;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [KEY_WIDTH-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			key_signed_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				stcfs_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data;
				stcfs_pkg::CFG_KEY_SIGNED:  key_signed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = ctrl.take_in;
	assign idx_wide = 32'(entry_index);
	assign wr_wide = 64'(write_value);
	assign wr_en = in_valid && in_ready && command == stcfs_pkg::CMD_WRITE &&
		idx_wide < 32'(TABLE_DEPTH);

	stcfs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	stcfs_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.ADDR_W      (ADDR_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_wide[ADDR_W-1:0]),
		.wr_data (wr_wide[KEY_WIDTH-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	stcfs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.ADDR_W      (ADDR_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.in_valid        (in_valid),
		.command         (command),
		.search_key      (search_key),
		.entry_count     (entry_count_q),
		.key_signed      (key_signed_q),
		.rd_data         (rd_data),
		.out_ready       (out_ready),
		.status          (status),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.out_valid       (out_valid),
		.found           (found),
		.position        (position),
		.key_at_position (key_at_position)
	);

	`STCFS_ASSERT_NEXT(a_search_blocks_input, clk, arst_n, in_valid && in_ready && (command == stcfs_pkg::CMD_CEIL || command == stcfs_pkg::CMD_FLOOR), !in_ready)
	`STCFS_ASSERT(a_miss_is_zero, clk, arst_n, out_valid && !found |-> position == '0 && key_at_position == '0)

endmodule
